// ===== src/i2cras_pkg.sv =====
// Shared types, codes and constants of the I2C register access sequencer.
`default_nettype none
package i2cras_pkg;

  localparam int unsigned AttemptLimitReset = 15;
  localparam int unsigned PaddrWidth        = 3;
  localparam int unsigned PdataWidth        = 32;

  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;
  localparam logic [1:0] MODE_BUSDONE = 2'd3;

  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_START   = 4'd1;
  localparam logic [3:0] CMD_RSTART  = 4'd2;
  localparam logic [3:0] CMD_SEND    = 4'd3;
  localparam logic [3:0] CMD_RECV    = 4'd4;
  localparam logic [3:0] CMD_STOP    = 4'd5;
  localparam logic [3:0] CMD_BACKOFF = 4'd6;
  localparam logic [3:0] CMD_NEED    = 4'd7;
  localparam logic [3:0] CMD_DONE    = 4'd8;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_NACK = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  localparam logic REG_ATTEMPT_LIMIT = 1'b0;

  typedef enum logic [10:0] {
    PH_IDLE    = 11'b000_0000_0001,
    PH_START   = 11'b000_0000_0010,
    PH_ADDR_W  = 11'b000_0000_0100,
    PH_REG     = 11'b000_0000_1000,
    PH_RSTART  = 11'b000_0001_0000,
    PH_ADDR_R  = 11'b000_0010_0000,
    PH_RX      = 11'b000_0100_0000,
    PH_NEED    = 11'b000_1000_0000,
    PH_TX      = 11'b001_0000_0000,
    PH_STOP    = 11'b010_0000_0000,
    PH_BACKOFF = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] attempts_used;
    logic [6:0] target_address;
    logic [7:0] register_number;
    logic       is_read;
    logic [7:0] bytes_left;
    logic [1:0] outcome;
  } ctx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] device_address;
    logic [7:0] register_index;
    logic [7:0] byte_count;
    logic [7:0] payload_byte;
    logic       bus_collision;
    logic       bus_nack;
    logic [7:0] bus_rx_byte;
  } req_t;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] command_byte;
    logic       ack_reply;
    logic [7:0] read_byte;
    logic       read_byte_valid;
    logic       read_byte_collided;
    logic [1:0] status;
  } res_t;

endpackage
`default_nettype wire

// ===== src/i2cras_step.sv =====
// Next-state and command decision for one request of the sequencer.
`default_nettype none
module i2cras_step
  import i2cras_pkg::*;
(
  input  ctx_t       ctx,
  input  req_t       req,
  input  logic [7:0] attempt_limit,
  output ctx_t       ctx_next,
  output res_t       res
);

  logic [7:0] bytes_dec;

  assign bytes_dec = (ctx.bytes_left != 8'd0) ? ctx.bytes_left - 8'd1 : 8'd0;

  always_comb begin
    ctx_next = ctx;
    res      = '0;
    if (req.mode inside {MODE_READ, MODE_WRITE}) begin
      if (ctx.phase == PH_IDLE) begin
        ctx_next.target_address  = req.device_address;
        ctx_next.register_number = req.register_index;
        ctx_next.bytes_left      = req.byte_count;
        ctx_next.is_read         = (req.mode == MODE_READ);
        ctx_next.attempts_used   = 8'd1;
        ctx_next.outcome         = ST_OK;
        ctx_next.phase           = PH_START;
        res.command              = CMD_START;
      end
    end else if (req.mode == MODE_PAYLOAD) begin
      if (ctx.phase == PH_NEED) begin
        res.command         = CMD_SEND;
        res.command_byte    = req.payload_byte;
        ctx_next.bytes_left = bytes_dec;
        ctx_next.phase      = PH_TX;
      end
    end else begin
      case (ctx.phase)
        PH_START, PH_RSTART: begin
          if (req.bus_collision) begin
            ctx_next.outcome = ST_BUSY;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end else begin
            res.command      = CMD_SEND;
            res.command_byte = {ctx.target_address, ctx.phase == PH_RSTART};
            ctx_next.phase   = (ctx.phase == PH_RSTART) ? PH_ADDR_R : PH_ADDR_W;
          end
        end
        PH_ADDR_W, PH_ADDR_R: begin
          if (req.bus_collision) begin
            ctx_next.outcome = ST_BUSY;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end else if (req.bus_nack) begin
            ctx_next.outcome = ST_NACK;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end else if (ctx.phase == PH_ADDR_W) begin
            res.command      = CMD_SEND;
            res.command_byte = ctx.register_number;
            ctx_next.phase   = PH_REG;
          end else if (ctx.bytes_left == 8'd0) begin
            ctx_next.outcome = ST_OK;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end else begin
            res.command    = CMD_RECV;
            res.ack_reply  = (ctx.bytes_left == 8'd1);
            ctx_next.phase = PH_RX;
          end
        end
        PH_REG: begin
          if (ctx.is_read) begin
            res.command    = CMD_RSTART;
            ctx_next.phase = PH_RSTART;
          end else if (ctx.bytes_left != 8'd0) begin
            res.command    = CMD_NEED;
            ctx_next.phase = PH_NEED;
          end else begin
            ctx_next.outcome = ST_OK;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end
        end
        PH_RX: begin
          res.read_byte          = req.bus_rx_byte;
          res.read_byte_valid    = 1'b1;
          res.read_byte_collided = req.bus_collision;
          ctx_next.bytes_left    = bytes_dec;
          if (bytes_dec != 8'd0) begin
            res.command    = CMD_RECV;
            res.ack_reply  = (bytes_dec == 8'd1);
            ctx_next.phase = PH_RX;
          end else begin
            ctx_next.outcome = ST_OK;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end
        end
        PH_TX: begin
          if (ctx.bytes_left != 8'd0) begin
            res.command    = CMD_NEED;
            ctx_next.phase = PH_NEED;
          end else begin
            ctx_next.outcome = ST_OK;
            ctx_next.phase   = PH_STOP;
            res.command      = CMD_STOP;
          end
        end
        PH_STOP: begin
          if (ctx.outcome == ST_BUSY && ctx.attempts_used < attempt_limit) begin
            res.command    = CMD_BACKOFF;
            ctx_next.phase = PH_BACKOFF;
          end else begin
            res.command    = CMD_DONE;
            res.status     = ctx.outcome;
            ctx_next.phase = PH_IDLE;
          end
        end
        PH_BACKOFF: begin
          ctx_next.attempts_used = ctx.attempts_used + 8'd1;
          ctx_next.outcome       = ST_OK;
          ctx_next.phase         = PH_START;
          res.command            = CMD_START;
        end
        default: begin
          ctx_next = ctx;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== src/i2c_register_access_sequencer.sv =====
// Top level: I2C register access sequencer with request and result registers.
// A request is held in the input register; its result is registered in the
// result register as it leaves. Throughput: one request per cycle unless
// out_stall holds a valid result; the transaction state updates as a request
// leaves the input register, so back-to-back requests need no gaps.
// Reset: synchronous rst empties both registers, sets phase idle, clears the
// transaction state and loads attempt_limit with 15.
`default_nettype none
module i2c_register_access_sequencer
  import i2cras_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            mode,
  input  wire logic [6:0]            device_address,
  input  wire logic [7:0]            register_index,
  input  wire logic [7:0]            byte_count,
  input  wire logic [7:0]            payload_byte,
  input  wire logic                  bus_collision,
  input  wire logic                  bus_nack,
  input  wire logic [7:0]            bus_rx_byte,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [3:0]                 command,
  output logic [7:0]                 command_byte,
  output logic                       ack_reply,
  output logic [7:0]                 read_byte,
  output logic                       read_byte_valid,
  output logic                       read_byte_collided,
  output logic [1:0]                 status,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PaddrWidth-1:0] paddr,
  input  wire logic [PdataWidth-1:0] pwdata,
  output logic [PdataWidth-1:0]      prdata,
  output logic                       pready
);

  logic       req_valid;
  req_t       req;
  res_t       res;
  res_t       res_next;
  ctx_t       ctx;
  ctx_t       ctx_next;
  logic [7:0] attempt_limit;
  logic       advance;
  logic       reg_sel;

  assign advance  = req_valid && (!out_valid || !out_stall);
  assign in_stall = req_valid && !advance;
  assign reg_sel  = (paddr[PaddrWidth-1] == REG_ATTEMPT_LIMIT);
  assign pready   = 1'b1;
  assign prdata   = reg_sel ? {{(PdataWidth-8){1'b0}}, attempt_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      attempt_limit <= 8'(AttemptLimitReset);
    end else if (psel && penable && pwrite && reg_sel) begin
      attempt_limit <= pwdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      req_valid <= 1'b1;
    end else if (advance) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req <= '{mode: mode, device_address: device_address,
               register_index: register_index, byte_count: byte_count,
               payload_byte: payload_byte, bus_collision: bus_collision,
               bus_nack: bus_nack, bus_rx_byte: bus_rx_byte};
    end
  end

  i2cras_step u_step (
    .ctx           (ctx),
    .req           (req),
    .attempt_limit (attempt_limit),
    .ctx_next      (ctx_next),
    .res           (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ctx <= '{phase: PH_IDLE, outcome: ST_OK, default: '0};
    end else if (advance) begin
      ctx <= ctx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign command            = res.command;
  assign command_byte       = res.command_byte;
  assign ack_reply          = res.ack_reply;
  assign read_byte          = res.read_byte;
  assign read_byte_valid    = res.read_byte_valid;
  assign read_byte_collided = res.read_byte_collided;
  assign status             = res.status;

endmodule
`default_nettype wire

// ===== sim/i2c_register_access_sequencer_checker.sv =====
// Scoreboard for the I2C register access sequencer: predicts each result and compares it.
`timescale 1ns / 1ps
module i2c_register_access_sequencer_checker
  import i2cras_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic [6:0]            device_address,
  input  logic [7:0]            register_index,
  input  logic [7:0]            byte_count,
  input  logic [7:0]            payload_byte,
  input  logic                  bus_collision,
  input  logic                  bus_nack,
  input  logic [7:0]            bus_rx_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [3:0]            command,
  input  logic [7:0]            command_byte,
  input  logic                  ack_reply,
  input  logic [7:0]            read_byte,
  input  logic                  read_byte_valid,
  input  logic                  read_byte_collided,
  input  logic [1:0]            status,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PaddrWidth-1:0] paddr,
  input  logic [PdataWidth-1:0] pwdata,
  output int                    fail_count,
  output int                    open_count
);

  phase_t     ph;
  logic [7:0] tries;
  logic [6:0] tgt_addr;
  logic [7:0] reg_num;
  logic       rd_txn;
  logic [7:0] left;
  logic [1:0] result_code;
  logic [7:0] att_limit;

  res_t expected_q[$];
  int   fails = 0;

  function automatic void begin_stop(inout res_t o, input logic [1:0] code);
    result_code = code;
    ph = PH_STOP;
    o.command = CMD_STOP;
  endfunction

  function automatic void begin_receive(inout res_t o);
    ph = PH_RX;
    o.command = CMD_RECV;
    o.ack_reply = (left == 8'd1);
  endfunction

  function automatic void next_payload_or_stop(inout res_t o);
    if (left != 8'd0) begin
      ph = PH_NEED;
      o.command = CMD_NEED;
    end else begin
      begin_stop(o, ST_OK);
    end
  endfunction

  function automatic res_t sequence_step(input req_t r);
    res_t o;
    o = '0;
    case (r.mode)
      MODE_READ, MODE_WRITE: begin
        if (ph == PH_IDLE) begin
          tgt_addr = r.device_address;
          reg_num = r.register_index;
          left = r.byte_count;
          rd_txn = (r.mode == MODE_READ);
          tries = 8'd1;
          result_code = ST_OK;
          ph = PH_START;
          o.command = CMD_START;
        end
      end
      MODE_PAYLOAD: begin
        if (ph == PH_NEED) begin
          o.command = CMD_SEND;
          o.command_byte = r.payload_byte;
          if (left != 8'd0) left--;
          ph = PH_TX;
        end
      end
      default: begin
        case (ph)
          PH_START, PH_RSTART: begin
            if (r.bus_collision) begin
              begin_stop(o, ST_BUSY);
            end else begin
              o.command = CMD_SEND;
              o.command_byte = {tgt_addr, ph == PH_RSTART};
              ph = (ph == PH_RSTART) ? PH_ADDR_R : PH_ADDR_W;
            end
          end
          PH_ADDR_W, PH_ADDR_R: begin
            if (r.bus_collision) begin
              begin_stop(o, ST_BUSY);
            end else if (r.bus_nack) begin
              begin_stop(o, ST_NACK);
            end else if (ph == PH_ADDR_W) begin
              o.command = CMD_SEND;
              o.command_byte = reg_num;
              ph = PH_REG;
            end else if (left == 8'd0) begin
              begin_stop(o, ST_OK);
            end else begin
              begin_receive(o);
            end
          end
          PH_REG: begin
            if (rd_txn) begin
              o.command = CMD_RSTART;
              ph = PH_RSTART;
            end else begin
              next_payload_or_stop(o);
            end
          end
          PH_RX: begin
            o.read_byte = r.bus_rx_byte;
            o.read_byte_valid = 1'b1;
            o.read_byte_collided = r.bus_collision;
            if (left != 8'd0) left--;
            if (left != 8'd0) begin_receive(o);
            else begin_stop(o, ST_OK);
          end
          PH_TX: next_payload_or_stop(o);
          PH_STOP: begin
            if (result_code == ST_BUSY && tries < att_limit) begin
              o.command = CMD_BACKOFF;
              ph = PH_BACKOFF;
            end else begin
              o.command = CMD_DONE;
              o.status = result_code;
              ph = PH_IDLE;
            end
          end
          PH_BACKOFF: begin
            tries++;
            result_code = ST_OK;
            o.command = CMD_START;
            ph = PH_START;
          end
          default: ;
        endcase
      end
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    res_t seen;
    res_t want;
    if (rst) begin
      ph = PH_IDLE;
      tries = '0;
      tgt_addr = '0;
      reg_num = '0;
      rd_txn = 1'b0;
      left = '0;
      result_code = ST_OK;
      att_limit = AttemptLimitReset[7:0];
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[PaddrWidth-1] == REG_ATTEMPT_LIMIT)
        att_limit = pwdata[7:0];
      if (out_valid && !out_stall) begin
        seen = {command, command_byte, ack_reply, read_byte, read_byte_valid,
                read_byte_collided, status};
        if (expected_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%0t: unexpected result, command %0d", $time, command);
        end else begin
          want = expected_q.pop_front();
          if (seen !== want) begin
            fails++;
            if (fails <= 10)
              $display({"%0t: mismatch (exp/got) cmd %0d/%0d byte %h/%h ack %b/%b ",
                        "rd %h/%h vld %b/%b col %b/%b status %0d/%0d"}, $time,
                       want.command, seen.command, want.command_byte, seen.command_byte,
                       want.ack_reply, seen.ack_reply, want.read_byte, seen.read_byte,
                       want.read_byte_valid, seen.read_byte_valid,
                       want.read_byte_collided, seen.read_byte_collided,
                       want.status, seen.status);
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(sequence_step({mode, device_address, register_index, byte_count,
                                            payload_byte, bus_collision, bus_nack,
                                            bus_rx_byte}));
    end
    fail_count <= fails;
    open_count <= expected_q.size();
  end

endmodule

// ===== sim/i2c_register_access_sequencer_tb.sv =====
// Testbench top for the I2C register access sequencer: stimulus, bus responder and verdict.
`timescale 1ns / 1ps
module i2c_register_access_sequencer_tb;
  import i2cras_pkg::*;

  localparam int unsigned CycleLimit     = 1_000_000;
  localparam int unsigned UnusedRegIndex = 1;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            mode;
  logic [6:0]            device_address;
  logic [7:0]            register_index;
  logic [7:0]            byte_count;
  logic [7:0]            payload_byte;
  logic                  bus_collision;
  logic                  bus_nack;
  logic [7:0]            bus_rx_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [3:0]            command;
  logic [7:0]            command_byte;
  logic                  ack_reply;
  logic [7:0]            read_byte;
  logic                  read_byte_valid;
  logic                  read_byte_collided;
  logic [1:0]            status;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PaddrWidth-1:0] paddr;
  logic [PdataWidth-1:0] pwdata;
  logic [PdataWidth-1:0] prdata;
  logic                  pready;

  int         fail_count;
  int         open_count;
  int         requests_sent = 0;
  int         results_seen;
  int         useful_results;
  logic [3:0] pending_cmd;
  logic       quiet;
  int         cycles = 0;
  int         stall_left = 0;

  i2c_register_access_sequencer i_dut (.*);

  i2c_register_access_sequencer_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // last command that did something tells where the transaction stands
  always @(posedge clk) begin
    if (rst) begin
      results_seen <= 0;
      useful_results <= 0;
      pending_cmd <= CMD_DONE;
    end else if (out_valid && !out_stall) begin
      results_seen <= results_seen + 1;
      if (command != CMD_NONE) begin
        pending_cmd <= command;
        useful_results <= useful_results + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic req_t random_item();
    logic [63:0] raw;
    req_t r;
    raw = {$urandom, $urandom};
    r = raw[$bits(req_t)-1:0];
    return r;
  endfunction

  task automatic send(input req_t r);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {mode, device_address, register_index, byte_count, payload_byte, bus_collision, bus_nack,
     bus_rx_byte} <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_seen != requests_sent);
  endtask

  // acts as bus engine and requester for the command last issued
  task automatic respond(input int coll_pct, input int nack_pct);
    req_t r;
    r = random_item();
    if ($urandom_range(0, 19) == 0) begin
      case ($urandom_range(0, 2))
        0: r.mode = MODE_READ;
        1: r.mode = MODE_WRITE;
        default: r.mode = (pending_cmd == CMD_NEED) ? MODE_BUSDONE : MODE_PAYLOAD;
      endcase
    end else if (pending_cmd == CMD_NEED) begin
      r.mode = MODE_PAYLOAD;
    end else begin
      r.mode = MODE_BUSDONE;
      r.bus_collision = ($urandom_range(0, 99) < coll_pct);
      r.bus_nack = ($urandom_range(0, 99) < nack_pct);
    end
    send(r);
    settle();
  endtask

  task automatic run_txn(input logic rd, input logic [6:0] addr, input logic [7:0] regno,
                         input logic [7:0] cnt, input int coll_pct, input int nack_pct);
    req_t r;
    r = random_item();
    r.mode = rd ? MODE_READ : MODE_WRITE;
    r.device_address = addr;
    r.register_index = regno;
    r.byte_count = cnt;
    send(r);
    settle();
    while (pending_cmd != CMD_DONE) respond(coll_pct, nack_pct);
  endtask

  // random requests, sometimes with gaps between them, then walk the block back to idle
  task automatic scramble(input int n, input int coll_pct, input int nack_pct);
    repeat (n) send(random_item());
    settle();
    while (pending_cmd != CMD_DONE) respond(coll_pct, nack_pct);
  endtask

  task automatic apb_write(input int unsigned idx, input logic [PdataWidth-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PaddrWidth'(idx * 4);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input int goal, input int coll_pct, input int nack_pct);
    logic [7:0] cnt;
    while (useful_results < goal) begin
      if ($urandom_range(0, 9) == 0) begin
        scramble($urandom_range(1, 8), coll_pct, nack_pct);
      end else begin
        cnt = ($urandom_range(0, 59) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 4));
        run_txn(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                8'($urandom_range(0, 255)), cnt, coll_pct, nack_pct);
      end
    end
  endtask

  initial begin
    req_t r;
    rst <= 1'b1;
    quiet <= 1'b0;
    in_valid <= 1'b0;
    {mode, device_address, register_index, byte_count, payload_byte, bus_collision, bus_nack,
     bus_rx_byte} <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray completion and stray payload while idle
    r = random_item();
    r.mode = MODE_BUSDONE;
    r.bus_collision = 1'b1;
    r.bus_nack = 1'b1;
    r.bus_rx_byte = 8'hFF;
    send(r);
    r.mode = MODE_PAYLOAD;
    r.payload_byte = 8'hFF;
    send(r);
    settle();
    run_txn(1'b0, 7'h7F, 8'hFF, 8'd0, 0, 0);
    run_txn(1'b1, 7'h00, 8'h00, 8'd0, 0, 100);
    run_txn(1'b0, 7'h55, 8'hAA, 8'd1, 0, 0);
    run_txn(1'b1, 7'h2A, 8'h55, 8'd2, 0, 0);

    random_phase(130, 10, 10);
    apb_write(REG_ATTEMPT_LIMIT, 32'd1);
    random_phase(260, 40, 10);
    apb_write(REG_ATTEMPT_LIMIT, 32'd255);
    random_phase(390, 15, 10);
    apb_write(REG_ATTEMPT_LIMIT, 32'd0);
    random_phase(520, 40, 10);
    apb_write(UnusedRegIndex, $urandom);
    apb_write(REG_ATTEMPT_LIMIT, 32'd3);
    random_phase(650, 60, 15);
    apb_write(REG_ATTEMPT_LIMIT, $urandom_range(1, 255));
    random_phase(800, 20, 10);
    quiet <= 1'b1;
    random_phase(950, 20, 10);

    settle();
    while (open_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/i2cras_pkg.sv
src/i2cras_step.sv
src/i2c_register_access_sequencer.sv
sim/i2c_register_access_sequencer_checker.sv
sim/i2c_register_access_sequencer_tb.sv
